// ===== rtl/slcdfw_pkg.sv =====
// ----------------------------------------------------------------------------
// slcdfw_pkg
// Shared constants, widths and the glyph table for the segment-LCD frame writer.
// ----------------------------------------------------------------------------
`default_nettype none

package slcdfw_pkg;

  // Operation codes carried in the opcode field.
  localparam logic OpCommand = 1'b0;
  localparam logic OpDigit   = 1'b1;

  // Frame lengths in wire bits and the width of the bit counter.
  localparam int FrameBitsMax = 17;
  localparam int CntW         = 5;
  localparam logic [CntW-1:0] FrameBitsCmd   = 5'd12;
  localparam logic [CntW-1:0] FrameBitsDigit = 5'd17;

  // Frame headers.
  localparam logic [3:0] CmdHeader  = 4'b1000;
  localparam logic [2:0] DataHeader = 3'b101;

  // Segment bit lit by the decimal point.
  localparam logic [7:0] PointMask = 8'h01;

  // Input word layout, lowest bit first.
  localparam int InDataW  = 24;
  localparam int OutDataW = 8;

  // Seven-segment glyph table; indices beyond the table give a blank glyph.
  function automatic logic [7:0] glyph(input logic [4:0] idx);
    logic [7:0] seg;
    case (idx)
      5'd0:    seg = 8'h5F;
      5'd1:    seg = 8'h06;
      5'd2:    seg = 8'h3D;
      5'd3:    seg = 8'h2F;
      5'd4:    seg = 8'h66;
      5'd5:    seg = 8'h4B;
      5'd6:    seg = 8'h7B;
      5'd7:    seg = 8'h0E;
      5'd8:    seg = 8'h7F;
      5'd9:    seg = 8'h6F;
      5'd10:   seg = 8'hEE;
      5'd11:   seg = 8'h76;
      5'd12:   seg = 8'hF0;
      5'd13:   seg = 8'h3E;
      5'd14:   seg = 8'hF4;
      5'd15:   seg = 8'hE4;
      5'd16:   seg = 8'hFE;
      5'd17:   seg = 8'hFE;
      5'd18:   seg = 8'h01;
      5'd19:   seg = 8'h6D;
      5'd20:   seg = 8'h31;
      5'd21:   seg = 8'h00;
      5'd22:   seg = 8'h40;
      5'd23:   seg = 8'h6E;
      5'd24:   seg = 8'h54;
      5'd25:   seg = 8'h50;
      5'd26:   seg = 8'h5C;
      5'd27:   seg = 8'h1C;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/segment_lcd_serial_frame_writer.sv =====
// A taken word is loaded into the frame shift register, and its first wire bit then moves to the output stage.
// Throughput: one bit per cycle while the output is not stalled, set by the single
// frame shift register; a command frame is 12 wire bits and a digit frame 17, and the
// next word is taken as the last bit leaves. A stalled output holds the shift register.
// Reset (rst_ni low, asynchronous) clears the bit count and the output valid flag.
// ----------------------------------------------------------------------------
// segment_lcd_serial_frame_writer
// Serialises command and digit write frames for a three-wire segment-LCD
// controller, most significant bit first, one wire bit per output word.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_lcd_serial_frame_writer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: opcode[0], command_code[8:1], position[13:9], digit[18:14],
  // point[19], zero padding[23:20]
  input  wire logic [23:0] s_axis_tdata,
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: data_bit[0], zero padding[7:1]
  output logic [7:0]       m_axis_tdata,
  // tlast: final bit of the frame, chip select released afterwards
  output logic             m_axis_tlast
);

  // Unpacked input fields.
  logic       in_opcode;
  logic [7:0] in_cmd;
  logic [4:0] in_pos;
  logic [4:0] in_digit;
  logic       in_point;

  assign in_opcode = s_axis_tdata[0];
  assign in_cmd    = s_axis_tdata[8:1];
  assign in_pos    = s_axis_tdata[13:9];
  assign in_digit  = s_axis_tdata[18:14];
  assign in_point  = s_axis_tdata[19];

  // Frame shift register, left aligned, and the count of bits still to send.
  logic [slcdfw_pkg::FrameBitsMax-1:0] shift_q, shift_d;
  logic [slcdfw_pkg::CntW-1:0]         cnt_q, cnt_d;

  // Output stage.
  logic out_valid_q, out_valid_d;
  logic out_bit_q, out_bit_d;
  logic out_last_q, out_last_d;

  logic busy;
  logic out_free;
  logic take;
  logic emit;

  // Frame assembly.
  logic [5:0] addr;
  logic [7:0] seg;
  logic [slcdfw_pkg::FrameBitsMax-1:0] frame;

  assign busy     = (cnt_q != '0);
  assign out_free = !out_valid_q || m_axis_tready;
  assign emit     = busy && out_free;
  // A new word is taken when idle or as the final bit moves to the output stage.
  assign s_axis_tready = !busy || (cnt_q == slcdfw_pkg::CntW'(1) && out_free);
  assign take     = s_axis_tvalid && s_axis_tready;

  // Build the frame for the incoming word.
  always_comb begin
    addr = {in_pos, 1'b0} - 6'd2;
    seg  = slcdfw_pkg::glyph(in_digit);
    if (in_point) begin
      seg = seg | slcdfw_pkg::PointMask;
    end
    if (in_opcode == slcdfw_pkg::OpCommand) begin
      frame = {slcdfw_pkg::CmdHeader, in_cmd, 5'b0};
    end else begin
      frame = {slcdfw_pkg::DataHeader, addr, seg};
    end
  end

  // Next state of the shift register and the output stage.
  always_comb begin
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_bit_d   = out_bit_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_bit_d   = shift_q[slcdfw_pkg::FrameBitsMax-1];
      out_last_d  = (cnt_q == slcdfw_pkg::CntW'(1));
      shift_d     = {shift_q[slcdfw_pkg::FrameBitsMax-2:0], 1'b0};
      cnt_d       = cnt_q - slcdfw_pkg::CntW'(1);
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      shift_d = frame;
      cnt_d   = (in_opcode == slcdfw_pkg::OpCommand) ? slcdfw_pkg::FrameBitsCmd
                                                      : slcdfw_pkg::FrameBitsDigit;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    shift_q    <= shift_d;
    out_bit_q  <= out_bit_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_bit_q};
  assign m_axis_tlast  = out_last_q;

  // The bit counter never exceeds the longest frame.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= slcdfw_pkg::FrameBitsDigit)
    else $error("bit counter beyond longest frame");

  // A taken word loads a full frame length.
  a_load_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (cnt_q == slcdfw_pkg::FrameBitsCmd || cnt_q == slcdfw_pkg::FrameBitsDigit))
    else $error("frame length not loaded on take");

  // A stalled output freezes an active frame.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && busy) |=> $stable(cnt_q))
    else $error("frame advanced during output stall");

  // Sending the final bit leaves the writer idle or starting a new frame.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cnt_q == slcdfw_pkg::CntW'(1)) |=>
      (cnt_q == '0 || cnt_q == slcdfw_pkg::FrameBitsCmd
       || cnt_q == slcdfw_pkg::FrameBitsDigit))
    else $error("frame did not end cleanly");

  // A bit emitted before the final bit of a frame never carries the last flag.
  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && cnt_q != slcdfw_pkg::CntW'(1)) |=> !m_axis_tlast)
    else $error("last flag raised mid frame");

endmodule

`default_nettype wire

// ===== tb/segment_lcd_serial_frame_writer_test.sv =====
// ----------------------------------------------------------------------------
// segment_lcd_serial_frame_writer_test
// Streams command and digit operations into the frame writer and checks every
// serialised wire bit, and the end-of-frame flag, against frames built in the
// bench. Directed frames cover the field extremes, out-of-range positions and
// glyph indices. Random traffic then runs under several source and sink idling
// mixes, with a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_lcd_serial_frame_writer_test;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted word before the run is abandoned.
  localparam int StallLimit  = 1000;
  // Quiet cycles after the last expected bit, to catch stray output words.
  localparam int DrainCycles = 20;
  // Length of the long output hold-off.
  localparam int HoldOffCycles = 250;

  // Seven-segment glyphs, index 0 in the lowest byte.
  localparam logic [28*8-1:0] GlyphRom = {
    8'h1C, 8'h5C, 8'h50, 8'h54, 8'h6E, 8'h40, 8'h00, 8'h31, 8'h6D, 8'h01,
    8'hFE, 8'hFE, 8'hE4, 8'hF4, 8'h3E, 8'hF0, 8'h76, 8'hEE, 8'h6F, 8'h7F,
    8'h0E, 8'h7B, 8'h4B, 8'h66, 8'h2F, 8'h3D, 8'h06, 8'h5F
  };

  typedef struct packed {
    logic data_bit;
    logic last;
  } wire_bit_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: opcode[0], command_code[8:1], position[13:9], digit[18:14],
  // point[19], zero padding[23:20]
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: data_bit[0], zero padding[7:1]
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  // Wire bits still to come, oldest first.
  wire_bit_t frame_bits_q[$];
  int        mismatch_count   = 0;
  int        src_idle_pct     = 0;
  int        sink_stall_pct   = 0;
  int        sink_hold_cycles = 0;

  segment_lcd_serial_frame_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Builds the frame for one input word and queues its bits, MSB first.
  function automatic void predict_frame(input logic [23:0] word);
    logic        op;
    logic [7:0]  cmd;
    logic [4:0]  pos;
    logic [4:0]  dig;
    logic        pt;
    logic [5:0]  addr;
    logic [7:0]  seg;
    logic [16:0] frame;
    int          nbits;
    wire_bit_t   wb;
    op  = word[0];
    cmd = word[8:1];
    pos = word[13:9];
    dig = word[18:14];
    pt  = word[19];
    if (op == slcdfw_pkg::OpCommand) begin
      frame = {5'b00000, slcdfw_pkg::CmdHeader, cmd};
      nbits = 12;
    end else begin
      // The address wraps modulo 64, so position 0 lands on 62.
      addr = {pos, 1'b0} - 6'd2;
      seg  = (dig < 5'd28) ? GlyphRom[int'(dig)*8 +: 8] : 8'h00;
      if (pt) seg = seg | slcdfw_pkg::PointMask;
      frame = {slcdfw_pkg::DataHeader, addr, seg};
      nbits = 17;
    end
    for (int i = nbits - 1; i >= 0; i--) begin
      wb.data_bit = frame[i];
      wb.last     = (i == 0);
      frame_bits_q.push_back(wb);
    end
  endfunction

  function automatic void report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", what);
  endfunction

  // Output side: checks each accepted word and drives tready.
  always @(posedge clk_i) begin
    wire_bit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_bits_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word tdata=%h tlast=%b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = frame_bits_q.pop_front();
        if (m_axis_tdata !== {7'b0000000, want.data_bit} || m_axis_tlast !== want.last)
          report_mismatch($sformatf("expected bit=%b last=%b, got tdata=%h tlast=%b",
                                    want.data_bit, want.last, m_axis_tdata,
                                    m_axis_tlast));
      end
    end
    if (sink_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Ends the run when no word moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Offers one operation and returns at the edge where it is taken.
  task automatic send_op(input logic op, input logic [7:0] cmd, input logic [4:0] pos,
                         input logic [4:0] dig, input logic pt);
    logic [23:0] word;
    word = {4'b0000, pt, dig, pos, cmd, op};
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_frame(word);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (frame_bits_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly nominal positions and glyphs, with some out-of-range values.
  task automatic send_random_op();
    logic [4:0] pos;
    logic [4:0] dig;
    if ($urandom_range(99) < 85) begin
      pos = 5'($urandom_range(16, 1));
      dig = 5'($urandom_range(27, 0));
    end else begin
      pos = 5'($urandom_range(31, 0));
      dig = 5'($urandom_range(31, 0));
    end
    send_op($urandom_range(1, 0) ? slcdfw_pkg::OpDigit : slcdfw_pkg::OpCommand,
            8'($urandom_range(255, 0)), pos, dig, 1'($urandom_range(1, 0)));
  endtask

  // Command frames with extreme and alternating codes; unused fields random.
  task automatic test_command_frames();
    logic [7:0] codes[8];
    codes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    foreach (codes[i])
      send_op(slcdfw_pkg::OpCommand, codes[i], 5'($urandom_range(31, 0)),
              5'($urandom_range(31, 0)), 1'($urandom_range(1, 0)));
  endtask

  // Digit frames at the position and glyph extremes, including wrapped
  // addresses, blank glyphs past the table and the decimal point.
  task automatic test_digit_frames();
    send_op(slcdfw_pkg::OpDigit, 8'hFF, 5'd1,  5'd0,  1'b0);
    send_op(slcdfw_pkg::OpDigit, 8'h00, 5'd16, 5'd27, 1'b1);
    send_op(slcdfw_pkg::OpDigit, 8'h5A, 5'd0,  5'd8,  1'b0);
    send_op(slcdfw_pkg::OpDigit, 8'hA5, 5'd17, 5'd21, 1'b1);
    send_op(slcdfw_pkg::OpDigit, 8'h00, 5'd31, 5'd31, 1'b0);
    send_op(slcdfw_pkg::OpDigit, 8'hFF, 5'd1,  5'd28, 1'b1);
    send_op(slcdfw_pkg::OpDigit, 8'h00, 5'd16, 5'd21, 1'b0);
    send_op(slcdfw_pkg::OpDigit, 8'h3C, 5'd8,  5'd18, 1'b0);
    send_op(slcdfw_pkg::OpDigit, 8'hC3, 5'd2,  5'd10, 1'b1);
    send_op(slcdfw_pkg::OpDigit, 8'h0F, 5'd15, 5'd31, 1'b1);
    send_op(slcdfw_pkg::OpDigit, 8'hF0, 5'd24, 5'd16, 1'b0);
    send_op(slcdfw_pkg::OpDigit, 8'h11, 5'd9,  5'd12, 1'b1);
  endtask

  task automatic test_random(input int count, input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (count) send_random_op();
  endtask

  // The sink holds off for a long stretch while the source keeps offering,
  // so the writer fills up and stalls its input.
  task automatic test_output_backpressure();
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    sink_hold_cycles = HoldOffCycles;
    repeat (20) send_random_op();
  endtask

  // The source pauses until every expected bit has come out, then resumes.
  task automatic test_pause_until_drained();
    src_idle_pct   = 0;
    sink_stall_pct = 34;
    repeat (5) send_random_op();
    stop_sending();
    wait_drained();
    repeat (5) send_random_op();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_command_frames();
    test_digit_frames();
    test_random(100, 0, 0);
    test_random(100, 54, 0);
    test_random(100, 0, 54);
    test_random(100, 34, 34);
    test_output_backpressure();
    test_pause_until_drained();

    stop_sending();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0 && frame_bits_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
